// ===== rtl/hspsu_pkg.sv =====
// Shared codes, types and arithmetic helpers of the humidity sensor poll sequencer.
package hspsu_pkg;

    // Input operation codes carried on tuser.
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_SEND_DONE = 2'd1;
    localparam logic [1:0] OP_READ_DONE = 2'd2;

    // Sequencer phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_CONV = 2'd2;
    localparam logic [1:0] PH_READ = 2'd3;

    // Request codes.
    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_MEASURE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_OK    = 3'd1;
    localparam logic [2:0] ST_BUS   = 3'd2;
    localparam logic [2:0] ST_CRC   = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_INTERVAL  = 3'd1;
    localparam logic [2:0] REG_CONV_TIME = 3'd2;
    localparam logic [2:0] REG_MAX_ERR   = 3'd3;
    localparam logic [2:0] REG_RETRY     = 3'd4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // Register reset values.
    localparam logic        RST_ENABLE    = 1'b1;
    localparam logic [15:0] RST_INTERVAL  = 16'd2000;
    localparam logic [7:0]  RST_CONV_TIME = 8'd20;
    localparam logic [7:0]  RST_MAX_ERR   = 8'd10;
    localparam logic [19:0] RST_RETRY     = 20'd60000;

    // Conversion constants. Raw words run over 0..65535 (full scale 65535).
    localparam int          WORD_FULL     = 65535;
    localparam logic [14:0] TEMP_SCALE    = 15'd17500;
    localparam logic [30:0] TEMP_OFFSET   = 31'(4500 * WORD_FULL);
    localparam logic [13:0] HUM_SCALE     = 14'd10000;
    localparam logic [13:0] HUM_MAX       = 14'd10000;
    // Raw temperature bounds equivalent to -40.00 .. 125.00 degrees, rounded inward.
    localparam logic [15:0] TEMP_RAW_MIN  = 16'((500 * WORD_FULL + 17499) / 17500);
    localparam logic [15:0] TEMP_RAW_MAX  = 16'((17000 * WORD_FULL) / 17500);

    localparam logic [7:0]  CRC_POLY = 8'h31;
    localparam logic [7:0]  CRC_INIT = 8'hFF;

    // Outcome of checking and converting one six-byte read.
    typedef struct packed {
        logic               crc_ok;
        logic               in_range;
        logic signed [14:0] temp;
        logic [13:0]        hum;
    } read_eval_t;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Floor of x / 65535 for x below 2^31. Since 65536 = 65535 + 1, the
    // remainder of the shift estimate is the low half plus the quotient,
    // which stays below twice the divisor, so one correction suffices.
    function automatic logic [14:0] div_full(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r;
        q0 = x[30:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        return (r >= 17'(WORD_FULL)) ? q0 + 15'd1 : q0;
    endfunction

endpackage

// ===== rtl/hspsu_read_eval.sv =====
// CRC check, range check and fixed-point conversion of one six-byte sensor read.
module hspsu_read_eval
(
    input  logic [7:0]            temp_high,
    input  logic [7:0]            temp_low,
    input  logic [7:0]            temp_check,
    input  logic [7:0]            hum_high,
    input  logic [7:0]            hum_low,
    input  logic [7:0]            hum_check,
    output hspsu_pkg::read_eval_t result
);

    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic [30:0] t_prod;
    logic [30:0] t_mag;
    logic        t_pos;
    logic [14:0] t_quot;
    logic [29:0] h_prod;
    logic [14:0] h_quot;
    logic [7:0]  t_crc;
    logic [7:0]  h_crc;

    assign raw_t = {temp_high, temp_low};
    assign raw_h = {hum_high, hum_low};

    assign t_crc = hspsu_pkg::crc8_byte(hspsu_pkg::crc8_byte(hspsu_pkg::CRC_INIT, temp_high),
                                        temp_low);
    assign h_crc = hspsu_pkg::crc8_byte(hspsu_pkg::crc8_byte(hspsu_pkg::CRC_INIT, hum_high),
                                        hum_low);

    // Temperature times 65535 in centidegrees is 17500 * raw - 4500 * 65535.
    // The quotient truncates toward zero, so divide the magnitude.
    assign t_prod = 31'(raw_t) * 31'(hspsu_pkg::TEMP_SCALE);
    assign t_pos  = (t_prod >= hspsu_pkg::TEMP_OFFSET);
    assign t_mag  = t_pos ? (t_prod - hspsu_pkg::TEMP_OFFSET)
                          : (hspsu_pkg::TEMP_OFFSET - t_prod);
    assign t_quot = hspsu_pkg::div_full(t_mag);

    assign h_prod = 30'(raw_h) * 30'(hspsu_pkg::HUM_SCALE);
    assign h_quot = hspsu_pkg::div_full({1'b0, h_prod});

    always_comb
    begin
        result.crc_ok   = (t_crc == temp_check) && (h_crc == hum_check);
        result.in_range = (raw_t >= hspsu_pkg::TEMP_RAW_MIN) &&
                          (raw_t <= hspsu_pkg::TEMP_RAW_MAX);
        result.temp     = t_pos ? $signed(t_quot) : -$signed(t_quot);
        if (h_quot > {1'b0, hspsu_pkg::HUM_MAX})
        begin
            result.hum = hspsu_pkg::HUM_MAX;
        end
        else
        begin
            result.hum = h_quot[13:0];
        end
    end

endmodule

// ===== rtl/humidity_sensor_poll_sequencer_unit.sv =====
// Top level of the humidity sensor poll sequencer: input stage, sequencer and result stage.
//
// Usage. Each input word on the slave stream is one event: a millisecond tick,
// a measure command send finished, or a six-byte read finished (kind on tuser,
// bus status and the six read bytes on tdata). For every input word the block
// returns exactly one output word on the master stream carrying the request to
// issue (none, measure command or six-byte read), the last status, the last
// good temperature and humidity in hundredths, a fresh-reading flag, the
// cooldown flag and the consecutive failure count.
// An input word waits in the input register, then passes through the sequencer logic into
// the result register. Throughput is one word per cycle while the receiver does not stall;
// the only loop is the sequencer state update.
// The input register accepts a new word whenever it is empty or its word moves
// on in the same cycle, so a waiting result does not block input. When the
// receiver stalls, the result register holds, then the input register fills,
// and only then is s_axis_tready dropped.
// Reset clears both stages, puts the sequencer in its idle phase with all counters and
// stored readings at zero, and loads the configuration defaults (enabled, 2000 ms interval,
// 20 ms conversion, 10 failures, 60000 ms retry). Configuration is written through
// cfg_wr_en/cfg_addr/cfg_wdata, by the user only while idle; the block does not enforce it.
module humidity_sensor_poll_sequencer_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [hspsu_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hspsu_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // bus_ok[0], temp_high[8:1], temp_low[16:9], temp_check[24:17],
    // hum_high[32:25], hum_low[40:33], hum_check[48:41], zero fill [55:49]
    input  logic [55:0]                      s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                       s_axis_tuser,
    // Output stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // request[1:0], status[4:2], temperature_centi[19:5], humidity_centi[33:20],
    // reading_fresh[34], cooling_down[35], failures[43:36], zero fill [47:44]
    output logic [47:0]                      m_axis_tdata
);

    // Configuration registers.
    logic        enable_reg;
    logic [15:0] interval_reg;
    logic [7:0]  conv_time_reg;
    logic [7:0]  max_err_reg;
    logic [19:0] retry_reg;

    // Input stage.
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  in_op_reg;
    logic        in_ok_reg;
    logic [7:0]  in_th_reg;
    logic [7:0]  in_tl_reg;
    logic [7:0]  in_tc_reg;
    logic [7:0]  in_hh_reg;
    logic [7:0]  in_hl_reg;
    logic [7:0]  in_hc_reg;

    // Sequencer state.
    logic [1:0]         phase_reg,  phase_next;
    logic [15:0]        since_reg,  since_next;
    logic [7:0]         conv_reg,   conv_next;
    logic [7:0]         fail_reg,   fail_next;
    logic [19:0]        cool_reg,   cool_next;
    logic [2:0]         status_reg, status_next;
    logic signed [14:0] temp_reg,   temp_next;
    logic [13:0]        hum_reg,    hum_next;

    // Result stage.
    logic               out_valid_reg;
    logic [1:0]         out_req_reg;
    logic [2:0]         out_status_reg;
    logic signed [14:0] out_temp_reg;
    logic [13:0]        out_hum_reg;
    logic               out_fresh_reg;
    logic               out_cool_reg;
    logic [7:0]         out_fail_reg;

    logic               in_take;
    logic               step;
    logic [1:0]         request;
    logic               fresh;
    logic [7:0]         fail_inc;
    logic [19:0]        cool_load;
    logic               run;
    hspsu_pkg::read_eval_t rd;

    // The sequencer advances when an input word is present and the result
    // register is free or being emptied in this cycle.
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    hspsu_read_eval u_read_eval
    (
        .temp_high  (in_th_reg),
        .temp_low   (in_tl_reg),
        .temp_check (in_tc_reg),
        .hum_high   (in_hh_reg),
        .hum_low    (in_hl_reg),
        .hum_check  (in_hc_reg),
        .result     (rd)
    );

    // Failure bookkeeping shared by send and read failures.
    assign fail_inc  = (fail_reg == 8'hFF) ? fail_reg : fail_reg + 8'd1;
    assign cool_load = (retry_reg == 20'd0) ? 20'd1 : retry_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        since_next  = since_reg;
        conv_next   = conv_reg;
        fail_next   = fail_reg;
        cool_next   = cool_reg;
        status_next = status_reg;
        temp_next   = temp_reg;
        hum_next    = hum_reg;
        request     = hspsu_pkg::REQ_NONE;
        fresh       = 1'b0;
        run         = 1'b1;

        if (enable_reg)
        begin
            if (in_op_reg == hspsu_pkg::OP_TICK)
            begin
                if (since_reg != 16'hFFFF)
                begin
                    since_next = since_reg + 16'd1;
                end
                if (cool_reg > 20'd1)
                begin
                    // Cooldown swallows the tick after counting it down.
                    cool_next = cool_reg - 20'd1;
                    run       = 1'b0;
                end
                else if (cool_reg == 20'd1)
                begin
                    cool_next  = 20'd0;
                    fail_next  = 8'd0;
                    phase_next = hspsu_pkg::PH_IDLE;
                end
                if (run)
                begin
                    if (phase_next == hspsu_pkg::PH_IDLE)
                    begin
                        if (since_next >= interval_reg)
                        begin
                            request    = hspsu_pkg::REQ_MEASURE;
                            phase_next = hspsu_pkg::PH_SEND;
                        end
                    end
                    else if (phase_next == hspsu_pkg::PH_CONV)
                    begin
                        if (conv_reg != 8'hFF)
                        begin
                            conv_next = conv_reg + 8'd1;
                        end
                        if (conv_next >= conv_time_reg)
                        begin
                            request    = hspsu_pkg::REQ_READ;
                            phase_next = hspsu_pkg::PH_READ;
                        end
                    end
                end
            end
            else if (cool_reg == 20'd0)
            begin
                if (in_op_reg == hspsu_pkg::OP_SEND_DONE && phase_reg == hspsu_pkg::PH_SEND)
                begin
                    if (in_ok_reg)
                    begin
                        phase_next = hspsu_pkg::PH_CONV;
                        conv_next  = 8'd0;
                    end
                    else
                    begin
                        // A failed send does not restart the interval.
                        phase_next  = hspsu_pkg::PH_IDLE;
                        status_next = hspsu_pkg::ST_BUS;
                        fail_next   = fail_inc;
                        if (fail_inc >= max_err_reg)
                        begin
                            cool_next = cool_load;
                        end
                    end
                end
                else if (in_op_reg == hspsu_pkg::OP_READ_DONE &&
                         phase_reg == hspsu_pkg::PH_READ)
                begin
                    phase_next = hspsu_pkg::PH_IDLE;
                    since_next = 16'd0;
                    if (!in_ok_reg || !rd.crc_ok)
                    begin
                        status_next = in_ok_reg ? hspsu_pkg::ST_CRC : hspsu_pkg::ST_BUS;
                        fail_next   = fail_inc;
                        if (fail_inc >= max_err_reg)
                        begin
                            cool_next = cool_load;
                        end
                    end
                    else if (!rd.in_range)
                    begin
                        // Out-of-range readings leave the failure count alone.
                        status_next = hspsu_pkg::ST_RANGE;
                    end
                    else
                    begin
                        temp_next   = rd.temp;
                        hum_next    = rd.hum;
                        status_next = hspsu_pkg::ST_OK;
                        fail_next   = 8'd0;
                        fresh       = 1'b1;
                    end
                end
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= hspsu_pkg::RST_ENABLE;
            interval_reg  <= hspsu_pkg::RST_INTERVAL;
            conv_time_reg <= hspsu_pkg::RST_CONV_TIME;
            max_err_reg   <= hspsu_pkg::RST_MAX_ERR;
            retry_reg     <= hspsu_pkg::RST_RETRY;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                hspsu_pkg::REG_ENABLE:    enable_reg    <= cfg_wdata[0];
                hspsu_pkg::REG_INTERVAL:  interval_reg  <= cfg_wdata[15:0];
                hspsu_pkg::REG_CONV_TIME: conv_time_reg <= cfg_wdata[7:0];
                hspsu_pkg::REG_MAX_ERR:   max_err_reg   <= cfg_wdata[7:0];
                hspsu_pkg::REG_RETRY:     retry_reg     <= cfg_wdata[19:0];
                default:                  ;
            endcase
        end
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg <= s_axis_tuser;
            in_ok_reg <= s_axis_tdata[0];
            in_th_reg <= s_axis_tdata[8:1];
            in_tl_reg <= s_axis_tdata[16:9];
            in_tc_reg <= s_axis_tdata[24:17];
            in_hh_reg <= s_axis_tdata[32:25];
            in_hl_reg <= s_axis_tdata[40:33];
            in_hc_reg <= s_axis_tdata[48:41];
        end
    end

    // Sequencer state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hspsu_pkg::PH_IDLE;
            since_reg     <= 16'd0;
            conv_reg      <= 8'd0;
            fail_reg      <= 8'd0;
            cool_reg      <= 20'd0;
            status_reg    <= hspsu_pkg::ST_NONE;
            temp_reg      <= 15'sd0;
            hum_reg       <= 14'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg  <= phase_next;
                since_reg  <= since_next;
                conv_reg   <= conv_next;
                fail_reg   <= fail_next;
                cool_reg   <= cool_next;
                status_reg <= status_next;
                temp_reg   <= temp_next;
                hum_reg    <= hum_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_req_reg    <= request;
            out_status_reg <= status_next;
            out_temp_reg   <= temp_next;
            out_hum_reg    <= hum_next;
            out_fresh_reg  <= fresh;
            out_cool_reg   <= (cool_next != 20'd0);
            out_fail_reg   <= fail_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_fail_reg, out_cool_reg, out_fresh_reg, out_hum_reg,
                            out_temp_reg, out_status_reg, out_req_reg};

endmodule
